>>> rtl/core/fac_chk_pkg.sv
// Package for the facility assignment cost checker.
// Holds the request and result types, field widths and cost limits.
// Used by the top level.
package fac_chk_pkg;

  localparam int FACILITY_W = 6;
  localparam int CAPACITY_W = 24;
  localparam int COST_W = 24;
  localparam int DEMAND_W = 16;
  localparam int TOTAL_W = 31;
  localparam int LOAD_W = 25;
  localparam int TABLE_W = CAPACITY_W + COST_W;

  localparam int DEFAULT_MAX_FACILITIES = 64;

  localparam logic [TOTAL_W-1:0] COST_INVALID = {TOTAL_W{1'b1}};
  localparam logic [TOTAL_W-1:0] COST_SAT = COST_INVALID - TOTAL_W'(1);
  localparam logic [LOAD_W-1:0] LOAD_SAT = {LOAD_W{1'b1}};

  typedef enum logic {
    CMD_LOAD     = 1'b0,
    CMD_CUSTOMER = 1'b1
  } command_t;

  typedef struct packed {
    command_t              command;
    logic [FACILITY_W-1:0] facility;
    logic [CAPACITY_W-1:0] capacity;
    logic [COST_W-1:0]     setup_cost;
    logic [DEMAND_W-1:0]   demand;
    logic [COST_W-1:0]     serve_cost;
    logic                  last;
  } request_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total_cost;
    logic               valid_res;
  } result_t;

endpackage

>>> rtl/core/fac_chk_ram.sv
// Simple dual-port RAM for the cost checker, one write and one read port.
// Read data is registered. Depends on nothing outside this file.
module fac_chk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/facility_assignment_cost_checker_core.sv
// Top level of the facility assignment cost checker.
// Depends on fac_chk_pkg and fac_chk_ram.
//
// One request is taken in every clock cycle while item_stall is low. A load request writes
// a facility's capacity and opening cost; customer requests then add opening and assignment
// costs and track the load on each facility. The customer request marked last yields one
// result, which passes from the s1 stage register into the output register, and the
// per-solution state is cleared at once, so the next solution may follow in the next cycle.
// The rate is set by the compute stage, which uses one read of each table, saturating load
// and cost adds and a capacity compare per cycle; a stalled result holds that stage only
// when it brings another result. Opened marks are flip-flops, all cleared at once, so there is no clearing pass.
module facility_assignment_cost_checker_core
  import fac_chk_pkg::*;
#(
  parameter int MAX_FACILITIES = DEFAULT_MAX_FACILITIES
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_stall,
  input  request_t item,
  output logic     result_valid,
  input  logic     result_stall,
  output result_t  result
);

  localparam int AW = $clog2(MAX_FACILITIES);

  logic                      accept;
  logic                      advance;
  logic                      produce;

  logic                      s1_valid;
  request_t                  s1_item;
  logic [AW-1:0]             s1_addr;
  logic                      in_range;

  logic [TABLE_W-1:0]        tbl_rdata;
  logic [LOAD_W-1:0]         load_rdata;
  logic                      tbl_fwd_valid;
  logic [AW-1:0]             tbl_fwd_addr;
  logic [TABLE_W-1:0]        tbl_fwd_data;
  logic                      load_fwd_valid;
  logic [AW-1:0]             load_fwd_addr;
  logic [LOAD_W-1:0]         load_fwd_data;

  logic [MAX_FACILITIES-1:0] opened;
  logic [MAX_FACILITIES-1:0] opened_next;
  logic [TOTAL_W-1:0]        running_cost;
  logic [TOTAL_W-1:0]        running_cost_next;
  logic                      still_valid;
  logic                      still_valid_next;

  logic [TABLE_W-1:0]        tbl_entry;
  logic [CAPACITY_W-1:0]     cap;
  logic [COST_W-1:0]         ocost;
  logic                      was_open;
  logic [LOAD_W-1:0]         load_old;
  logic [LOAD_W:0]           load_sum;
  logic [LOAD_W-1:0]         load_new;
  logic                      over;
  logic [COST_W:0]           add_amt;
  logic [TOTAL_W:0]          cost_sum;
  logic [TOTAL_W-1:0]        cost_new;
  logic                      valid_new;

  logic                      tbl_we;
  logic                      load_we;

  assign s1_addr = AW'(s1_item.facility);
  assign in_range = int'(s1_item.facility) < MAX_FACILITIES;

  assign produce = s1_valid && (s1_item.command == CMD_CUSTOMER) && s1_item.last;
  assign advance = s1_valid && (!produce || !result_valid || !result_stall);
  assign item_stall = s1_valid && !advance;
  assign accept = item_valid && !item_stall;

  assign tbl_we = advance && (s1_item.command == CMD_LOAD) && in_range;
  assign load_we = advance && (s1_item.command == CMD_CUSTOMER) && in_range;

  fac_chk_ram #(
    .WIDTH (TABLE_W),
    .DEPTH (MAX_FACILITIES)
  ) u_tables (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (s1_addr),
    .wdata ({s1_item.capacity, s1_item.setup_cost}),
    .re    (accept),
    .raddr (AW'(item.facility)),
    .rdata (tbl_rdata)
  );

  fac_chk_ram #(
    .WIDTH (LOAD_W),
    .DEPTH (MAX_FACILITIES)
  ) u_loads (
    .clk   (clk),
    .we    (load_we),
    .waddr (s1_addr),
    .wdata (load_new),
    .re    (accept),
    .raddr (AW'(item.facility)),
    .rdata (load_rdata)
  );

  always_comb begin
    tbl_entry = (tbl_fwd_valid && tbl_fwd_addr == s1_addr) ? tbl_fwd_data : tbl_rdata;
    cap = tbl_entry[TABLE_W-1:COST_W];
    ocost = tbl_entry[COST_W-1:0];
    was_open = in_range ? opened[s1_addr] : 1'b1;

    if (!was_open) begin
      load_old = '0;
    end else if (load_fwd_valid && load_fwd_addr == s1_addr) begin
      load_old = load_fwd_data;
    end else begin
      load_old = load_rdata;
    end
    load_sum = {1'b0, load_old} + (LOAD_W + 1)'(s1_item.demand);
    load_new = (load_sum > {1'b0, LOAD_SAT}) ? LOAD_SAT : load_sum[LOAD_W-1:0];
    over = load_new > LOAD_W'(cap);

    add_amt = (was_open ? (COST_W + 1)'(0) : {1'b0, ocost}) + {1'b0, s1_item.serve_cost};
    cost_sum = {1'b0, running_cost} + (TOTAL_W + 1)'(add_amt);
    cost_new = (cost_sum > {1'b0, COST_SAT}) ? COST_SAT : cost_sum[TOTAL_W-1:0];
    valid_new = still_valid && in_range && !over;

    opened_next = opened;
    running_cost_next = running_cost;
    still_valid_next = still_valid;
    if (advance && s1_item.command == CMD_CUSTOMER) begin
      if (s1_item.last) begin
        opened_next = '0;
        running_cost_next = '0;
        still_valid_next = 1'b1;
      end else begin
        if (in_range) begin
          opened_next[s1_addr] = 1'b1;
        end
        running_cost_next = cost_new;
        still_valid_next = valid_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      tbl_fwd_valid <= 1'b0;
      load_fwd_valid <= 1'b0;
      opened <= '0;
      running_cost <= '0;
      still_valid <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (tbl_we) begin
        tbl_fwd_valid <= 1'b1;
      end
      if (load_we) begin
        load_fwd_valid <= 1'b1;
      end
      opened <= opened_next;
      running_cost <= running_cost_next;
      still_valid <= still_valid_next;
      if (produce && advance) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
    if (tbl_we) begin
      tbl_fwd_addr <= s1_addr;
      tbl_fwd_data <= {s1_item.capacity, s1_item.setup_cost};
    end
    if (load_we) begin
      load_fwd_addr <= s1_addr;
      load_fwd_data <= load_new;
    end
    if (produce && advance) begin
      result.total_cost <= valid_new ? cost_new : COST_INVALID;
      result.valid_res <= valid_new;
    end
  end

  a_invalid_cost : assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.valid_res |-> result.total_cost == COST_INVALID)
    else $error("Invalid solution does not report the invalid cost.");

  a_valid_cost : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.valid_res |-> result.total_cost <= COST_SAT)
    else $error("Valid solution cost exceeds the saturation limit.");

  a_running_sat : assert property (@(posedge clk) disable iff (rst)
    running_cost <= COST_SAT)
    else $error("Running cost exceeds the saturation limit.");

  a_clear_after_last : assert property (@(posedge clk) disable iff (rst)
    produce && advance |=> running_cost == '0 && still_valid && opened == '0 && result_valid)
    else $error("Solution state not cleared after the last customer.");

endmodule
